FILE: hdl/isrt_pkg.sv
// Shared constants and types for the insertion sorter.
package isrt_pkg;

  localparam int DEPTH   = 16;
  localparam int VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    value_t value;
    logic   valid;
    logic   greater;
  } isrt_link_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic   insert;
    logic   shift;
    value_t new_value;
  } isrt_cmd_t;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } isrt_state_t;

endpackage

FILE: hdl/isrt_if.sv
// Valid/ready channel interfaces for the insertion sorter.
interface isrt_in_if;
  logic                       valid;
  logic                       ready;
  logic signed [isrt_pkg::VALUE_W-1:0] value;
  logic                       last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface isrt_out_if;
  logic                       valid;
  logic                       ready;
  logic signed [isrt_pkg::VALUE_W-1:0] sorted_value;
  logic                       final_res;
  logic                       overflow;

  modport source (output valid, output sorted_value, output final_res, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input final_res, input overflow,
                  output ready);
endinterface

FILE: hdl/isrt_cell.sv
// One entry of the sorted chain: holds a value and inserts or shifts.
module isrt_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  isrt_pkg::isrt_cmd_t  cmd,
  input  isrt_pkg::isrt_link_t left,
  input  isrt_pkg::isrt_link_t right,
  output isrt_pkg::isrt_link_t self
);
  import isrt_pkg::*;

  value_t value;
  logic   valid;
  logic   greater;

  // Strictly greater keeps equal values in arrival order.
  assign greater = valid && (value > cmd.new_value);

  assign self.value   = value;
  assign self.valid   = valid;
  assign self.greater = greater;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.insert) begin
      if (left.greater) begin
        // make room: take the left neighbor's entry
        value <= left.value;
        valid <= left.valid;
      end else if (left.valid && (greater || !valid)) begin
        value <= cmd.new_value;
        valid <= 1'b1;
      end
    end else if (cmd.shift) begin
      value <= right.value;
      valid <= right.valid;
    end
  end

endmodule

FILE: hdl/insertion_sorter_core.sv
// Top level: stable insertion sorter built from a chain of compare cells.
//
//  channel | dir | fields                               | handshake
//  din     | in  | value[31:0] signed, last             | valid/ready
//  dout    | out | sorted_value[31:0] signed, final_res, | valid/ready
//          |     | overflow                             |
//
// While filling, one item is taken every cycle; every cell compares against
// the new value at once and the chain opens a slot in that same cycle.
// On an item with last, the first result shows in the next cycle and the batch
// drains from cell 0, one result per cycle that dout accepts; din is held off
// until the final result is taken.
// Synchronous reset empties the chain and clears the overflow mark.
// A stall on dout simply holds the chain and the current result.
module insertion_sorter_core (
  input logic       clk,
  input logic       rst,
  isrt_in_if.sink   din,
  isrt_out_if.source dout
);
  import isrt_pkg::*;

  isrt_state_t state, state_next;
  logic        overflow_seen, overflow_seen_next;
  isrt_cmd_t   cmd;
  isrt_link_t  links [DEPTH];
  isrt_link_t  edge_left, edge_right;
  logic        full, in_acc, out_acc;

  assign full    = links[DEPTH-1].valid;
  assign in_acc  = din.valid && din.ready;
  assign out_acc = dout.valid && dout.ready;

  // Boundary links: cell 0 may always take the new value; the tail refills empty.
  assign edge_left  = '{value: '0, valid: 1'b1, greater: 1'b0};
  assign edge_right = '{value: '0, valid: 1'b0, greater: 1'b0};

  assign cmd.insert    = in_acc && !full;
  assign cmd.shift     = out_acc;
  assign cmd.new_value = din.value;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      isrt_link_t l_link, r_link;
      if (i == 0) begin : g_first
        assign l_link = edge_left;
      end else begin : g_mid_l
        assign l_link = links[i-1];
      end
      if (i == DEPTH-1) begin : g_last
        assign r_link = edge_right;
      end else begin : g_mid_r
        assign r_link = links[i+1];
      end
      isrt_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .cmd   (cmd),
        .left  (l_link),
        .right (r_link),
        .self  (links[i])
      );
    end
  endgenerate

  // next state
  always_comb begin
    state_next         = state;
    overflow_seen_next = overflow_seen;
    case (state)
      ST_FILL: begin
        if (in_acc && full) overflow_seen_next = 1'b1;
        if (in_acc && din.last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (out_acc && dout.final_res) begin
          state_next         = ST_FILL;
          overflow_seen_next = 1'b0;
        end
      end
      default: state_next = ST_FILL;
    endcase
  end

  // outputs
  always_comb begin
    din.ready  = 1'b0;
    dout.valid = 1'b0;
    case (state)
      ST_FILL:  din.ready  = 1'b1;
      ST_DRAIN: dout.valid = 1'b1;
      default: begin
        din.ready  = 1'b0;
        dout.valid = 1'b0;
      end
    endcase
  end

  assign dout.sorted_value = links[0].value;
  assign dout.final_res    = !links[1].valid;
  assign dout.overflow     = overflow_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_FILL;
      overflow_seen <= 1'b0;
    end else begin
      state         <= state_next;
      overflow_seen <= overflow_seen_next;
    end
  end

endmodule
